### rtl/wsfhe_pkg.sv
package wsfhe_pkg;

  localparam int TAIL_BYTES = 13;
  localparam int TAIL_W     = TAIL_BYTES * 8;
  localparam int CNT_W      = 4;

  localparam logic       OP_HEADER   = 1'b0;
  localparam logic       OP_PAYLOAD  = 1'b1;
  localparam logic [7:0] FIN_BIT     = 8'h80;
  localparam logic [7:0] OPC_TEXT    = 8'h01;
  localparam logic [7:0] MASK_BIT    = 8'h80;
  localparam logic [31:0] LEN_7_MAX  = 32'd125;
  localparam logic [31:0] LEN_16_MAX = 32'h0000_FFFF;
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  typedef struct packed {
    logic        op;
    logic [7:0]  first_byte;
    logic [31:0] mask_key;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        payload_last;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_last;
  } res_t;

  typedef struct packed {
    logic [7:0]        head;
    logic [TAIL_W-1:0] tail;
    logic [CNT_W-1:0]  count;
    logic              empty;
  } load_t;

endpackage

### rtl/websocket_frame_header_encoder.sv
// WebSocket frame header encoder.
// An item is offered on cmd with start and is taken at a clock edge where
// start is high and busy is low. A header item (op 0) expands into the
// frame's header bytes: the first byte with FIN forced (a zero opcode made text), the mask bit and
// length code, an optional 16- or 64-bit extended length and an optional
// four-byte mask key. A payload item (op 1) yields its byte unchanged.
// Each result byte is held on result for exactly one cycle with strobe
// high, beginning the cycle after the item is taken.
// A payload item does not raise busy, so payload bytes may stream at one
// per cycle while busy is low. A header item yields 2 to 14 bytes: the
// first from the item, the rest from the byte shift register that holds the
// remaining header bytes; busy is high until its last byte is on the port.
// Synchronous reset empties the shift register and clears strobe; no item
// is lost or repeated afterwards. The receiver has no way to stall, so
// every strobed byte must be taken in the cycle it is shown.
module websocket_frame_header_encoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  wsfhe_pkg::cmd_t   cmd,
  output logic              strobe,
  output wsfhe_pkg::res_t   result
);
  import wsfhe_pkg::*;

  logic             accept;
  load_t            ld;
  logic [7:0]       top_byte;
  logic [CNT_W-1:0] rem;
  logic             empty;

  assign busy   = (rem != '0);
  assign accept = start && !busy;

  wsfhe_pack u_pack (
    .cmd (cmd),
    .ld  (ld)
  );

  wsfhe_shreg u_shreg (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && (cmd.op == OP_HEADER)),
    .ld       (ld),
    .top_byte (top_byte),
    .rem      (rem),
    .empty    (empty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= accept || busy;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (cmd.op == OP_PAYLOAD) begin
        result <= '{out_byte: cmd.payload_byte, run_last: 1'b1,
                    frame_last: cmd.payload_last};
      end else begin
        result <= '{out_byte: ld.head, run_last: 1'b0, frame_last: 1'b0};
      end
    end else if (busy) begin
      result <= '{out_byte: top_byte, run_last: (rem == CNT_W'(1)),
                  frame_last: (rem == CNT_W'(1)) && empty};
    end
  end

  a_busy_strobes: assert property (@(posedge clk) disable iff (rst)
    busy |=> strobe)
    else $error("header byte pending without a strobe");

  a_accept_strobes: assert property (@(posedge clk) disable iff (rst)
    accept |=> strobe)
    else $error("taken item produced no byte");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.run_last) |-> !busy)
    else $error("still busy after the last byte of an item");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !strobe |-> !busy)
    else $error("busy while no byte is being shown");

endmodule

### rtl/wsfhe_pack.sv
module wsfhe_pack (
  input  wsfhe_pkg::cmd_t  cmd,
  output wsfhe_pkg::load_t ld
);
  import wsfhe_pkg::*;

  logic       keyed;
  logic [7:0] b2;

  assign keyed = (cmd.mask_key != 32'd0);

  always_comb begin
    ld = '0;
    ld.head = cmd.first_byte | FIN_BIT;
    if (cmd.first_byte[3:0] == 4'd0) begin
      ld.head = ld.head | OPC_TEXT;
    end
    ld.empty = (cmd.payload_length == 32'd0);
    b2 = keyed ? MASK_BIT : 8'd0;
    if (cmd.payload_length <= LEN_7_MAX) begin
      ld.tail  = {b2 | {1'b0, cmd.payload_length[6:0]}, cmd.mask_key, 64'd0};
      ld.count = keyed ? CNT_W'(5) : CNT_W'(1);
    end else if (cmd.payload_length <= LEN_16_MAX) begin
      ld.tail  = {b2 | {1'b0, LEN_CODE_16}, cmd.payload_length[15:0], cmd.mask_key, 48'd0};
      ld.count = keyed ? CNT_W'(7) : CNT_W'(3);
    end else begin
      ld.tail  = {b2 | {1'b0, LEN_CODE_64}, 32'd0, cmd.payload_length, cmd.mask_key};
      ld.count = keyed ? CNT_W'(13) : CNT_W'(9);
    end
  end

endmodule

### rtl/wsfhe_shreg.sv
module wsfhe_shreg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  wsfhe_pkg::load_t                 ld,
  output logic [7:0]                       top_byte,
  output logic [wsfhe_pkg::CNT_W-1:0]      rem,
  output logic                             empty
);
  import wsfhe_pkg::*;

  logic [TAIL_W-1:0] tail;

  assign top_byte = tail[TAIL_W-1 -: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= ld.count;
    end else if (rem != '0) begin
      rem <= rem - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tail  <= ld.tail;
      empty <= ld.empty;
    end else if (rem != '0) begin
      tail <= {tail[TAIL_W-9:0], 8'd0};
    end
  end

endmodule
